>>> rtl/aes_ctr_stream_cipher_defines.svh
// Assertion macros for the AES-CTR byte stream block.
`ifndef AES_CTR_STREAM_CIPHER_DEFINES_SVH
`define AES_CTR_STREAM_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define ACSC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("acsc: same-cycle check failed");
`define ACSC_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("acsc: next-cycle check failed");
`else
`define ACSC_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define ACSC_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

>>> rtl/acsc_pkg.sv
`default_nettype none
package acsc_pkg;

    localparam logic [2:0] CFG_KEY_MODE  = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD0 = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD1 = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD2 = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD3 = 3'd4;
    localparam logic [2:0] CFG_NONCE     = 3'd5;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;

    typedef struct packed {
        logic capture;
        logic gen_step;
        logic emit_in;
        logic emit_held;
    } cmd_t;

    typedef struct packed {
        logic need_ks;
        logic gen_last;
    } status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit block; byte 0 sits in the top bits.
    function automatic logic [7:0] get_byte(input logic [127:0] v, input logic [3:0] i);
        return v[{4'd15 - i, 3'b000} +: 8];
    endfunction

    // SubBytes, ShiftRows and, when mix is set, MixColumns.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [7:0] a [16];
        logic [7:0] t [16];
        logic [7:0] all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) begin
            a[i] = SBOX[s[127 - 8 * i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4 * c] = a[r + 4 * ((c + r) % 4)];
            end
        end
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                a[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
                a[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
                a[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
                a[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
            end
        end else begin
            for (int i = 0; i < 16; i++) begin
                a[i] = t[i];
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8 * i -: 8] = a[i];
        end
        return res;
    endfunction

    // Counter bytes in little-endian order, first byte in the top bits.
    function automatic logic [63:0] byte_swap(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[63 - 8 * i -: 8] = v[8 * i +: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/acsc_in_if.sv
`default_nettype none
interface acsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface
`default_nettype wire

>>> rtl/acsc_out_if.sv
`default_nettype none
interface acsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/acsc_ctrl.sv
`default_nettype none
module acsc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire acsc_pkg::status_t status,
    output acsc_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.need_ks)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_GEN;
                    end
                    else
                    begin
                        cmd.emit_in    = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_GEN:
            begin
                cmd.gen_step = 1'b1;
                if (status.gen_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_held  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/acsc_datapath.sv
`default_nettype none
module acsc_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,
    input  wire logic [7:0]        data_byte,
    input  wire logic              start_req,
    input  wire acsc_pkg::cmd_t    cmd,
    output acsc_pkg::status_t      status,
    output logic [7:0]             out_byte
);

    logic [1:0]   key_mode_reg;
    logic [63:0]  key_reg [4];
    logic [63:0]  nonce_reg;
    logic [63:0]  ctr_reg;
    logic [3:0]   pos_reg;
    logic [5:0]   wi_reg;
    logic [2:0]   mod_reg;
    logic [3:0]   rc_reg;
    logic [31:0]  win_reg [8];
    logic [95:0]  rk_reg;
    logic [127:0] st_reg;
    logic [127:0] ks_reg;
    logic [7:0]   data_reg;
    logic [7:0]   out_byte_reg;

    logic [2:0]   nk_m1;
    logic [5:0]   last_idx;
    logic [3:0]   nr;
    logic [63:0]  kw;
    logic [31:0]  tmp;
    logic [31:0]  word_next;
    logic [127:0] rkey;
    logic [127:0] st_next;
    logic [7:0]   src_byte;

    always_comb
    begin
        case (key_mode_reg)
            acsc_pkg::MODE_128:
            begin
                nk_m1    = 3'd3;
                last_idx = 6'd43;
            end
            acsc_pkg::MODE_192:
            begin
                nk_m1    = 3'd5;
                last_idx = 6'd51;
            end
            default:
            begin
                nk_m1    = 3'd7;
                last_idx = 6'd59;
            end
        endcase
        nr = {1'b0, nk_m1} + 4'd7;

        // One key schedule word per step, from a window of the last eight.
        kw  = key_reg[wi_reg[2:1]];
        tmp = win_reg[0];
        if (mod_reg == 3'd0)
        begin
            tmp = acsc_pkg::sub_word({tmp[23:0], tmp[31:24]}) ^
                  {acsc_pkg::rcon(rc_reg), 24'h000000};
        end
        else if (nk_m1 == 3'd7 && mod_reg == 3'd4)
        begin
            tmp = acsc_pkg::sub_word(tmp);
        end
        if (wi_reg <= {3'b000, nk_m1})
        begin
            word_next = wi_reg[0] ? kw[31:0] : kw[63:32];
        end
        else
        begin
            word_next = win_reg[nk_m1] ^ tmp;
        end

        rkey = {rk_reg, word_next};
        if (wi_reg[5:2] == 4'd0)
        begin
            st_next = {nonce_reg, acsc_pkg::byte_swap(ctr_reg)} ^ rkey;
        end
        else
        begin
            st_next = acsc_pkg::aes_round(st_reg, wi_reg[5:2] != nr) ^ rkey;
        end

        src_byte = cmd.emit_in ? data_byte : data_reg;
    end

    assign status.need_ks  = start_req || (pos_reg == 4'd0);
    assign status.gen_last = (wi_reg == last_idx);
    assign out_byte        = out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg <= '0;
            key_reg[0]   <= '0;
            key_reg[1]   <= '0;
            key_reg[2]   <= '0;
            key_reg[3]   <= '0;
            nonce_reg    <= '0;
            ctr_reg      <= '0;
            pos_reg      <= '0;
            wi_reg       <= '0;
            mod_reg      <= '0;
            rc_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    acsc_pkg::CFG_KEY_MODE:  key_mode_reg <= cfg_data[1:0];
                    acsc_pkg::CFG_KEY_WORD0: key_reg[0]   <= cfg_data;
                    acsc_pkg::CFG_KEY_WORD1: key_reg[1]   <= cfg_data;
                    acsc_pkg::CFG_KEY_WORD2: key_reg[2]   <= cfg_data;
                    acsc_pkg::CFG_KEY_WORD3: key_reg[3]   <= cfg_data;
                    acsc_pkg::CFG_NONCE:     nonce_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.capture)
            begin
                if (start_req)
                begin
                    ctr_reg <= '0;
                    pos_reg <= '0;
                end
                wi_reg  <= '0;
                mod_reg <= '0;
                rc_reg  <= '0;
            end
            if (cmd.gen_step)
            begin
                wi_reg <= wi_reg + 6'd1;
                if (mod_reg == nk_m1)
                begin
                    mod_reg <= '0;
                    rc_reg  <= rc_reg + 4'd1;
                end
                else
                begin
                    mod_reg <= mod_reg + 3'd1;
                end
            end
            if (cmd.emit_in || cmd.emit_held)
            begin
                pos_reg <= pos_reg + 4'd1;
                if (pos_reg == 4'd15)
                begin
                    ctr_reg <= ctr_reg + 64'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            data_reg <= data_byte;
        end
        if (cmd.gen_step)
        begin
            win_reg[0] <= word_next;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            rk_reg <= rkey[95:0];
            if (wi_reg[1:0] == 2'd3)
            begin
                st_reg <= st_next;
            end
            if (status.gen_last)
            begin
                ks_reg <= st_next;
            end
        end
        if (cmd.emit_in || cmd.emit_held)
        begin
            out_byte_reg <= src_byte ^ acsc_pkg::get_byte(ks_reg, pos_reg);
        end
    end

endmodule
`default_nettype wire

>>> rtl/aes_ctr_stream_cipher.sv
// Channel  | Dir | Word fields           | Handshake
// din      | in  | data_byte, start_req  | valid/ready
// dout     | out | out_byte              | valid/ready
// cfg      | in  | cfg_index, cfg_data   | cfg_we, no wait
//
// A byte inside a keystream block is ciphered from the held keystream. For a byte at
// block position zero, or one with start_req set, the AES core first expands one key
// word per cycle and applies a round every fourth word; out_byte is registered in EMIT
// after the final round, and din reopens with idle once dout can take the byte.
// rst_n clears position, counter and configuration at once.
// din stalls while a keystream block is built and emitted, or while dout is full.
`default_nettype none
`include "aes_ctr_stream_cipher_defines.svh"
module aes_ctr_stream_cipher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    acsc_in_if.sink          din,
    acsc_out_if.source       dout,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    acsc_pkg::cmd_t    cmd;
    acsc_pkg::status_t status;

    // Sequencer: decides per word whether a new keystream block is needed.
    acsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Key schedule, round unit, counter and keystream hold.
    acsc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (din.data_byte),
        .start_req (din.start_req),
        .cmd       (cmd),
        .status    (status),
        .out_byte  (dout.out_byte)
    );

    // No word is taken while the round unit is busy.
    `ACSC_ASSERT_IMP(a_no_accept_in_gen, clk, rst_n, cmd.gen_step, !din.ready)
    // The final round hands over to the held-byte emit.
    `ACSC_ASSERT_NXT(a_last_then_emit, clk, rst_n, cmd.gen_step && status.gen_last,
                     cmd.emit_held)
    // The output slot is always free when the held byte lands.
    `ACSC_ASSERT_IMP(a_emit_slot_free, clk, rst_n, cmd.emit_held, !dout.valid)

endmodule
`default_nettype wire

>>> test/aes_ctr_stream_cipher_tb.sv
`default_nettype none
module aes_ctr_stream_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_COUNT = 1900;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;

    // Words for the directed table: data, start flag, and an expected byte
    // only where it is obvious without running the cipher.
    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       has_exp;
        logic [7:0] exp_byte;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;

    acsc_in_if  din ();
    acsc_out_if dout ();

    aes_ctr_stream_cipher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din.sink),
        .dout      (dout.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the cipher configuration and stream state.
    logic [1:0]   sh_mode;
    logic [63:0]  sh_key [4];
    logic [63:0]  sh_nonce;
    logic [63:0]  sh_counter;
    logic [127:0] sh_keystream;
    logic [3:0]   sh_pos;

    logic [7:0] cipher_bytes_q [$];
    int  mismatch_count;
    int  cycle_count;
    bit  rx_stall_on;
    bit  tx_idle_on;
    bit  drive_done;

    localparam logic [7:0] SB [256] = acsc_pkg::SBOX;

    function automatic logic [7:0] mul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Standard AES encryption of one block; byte 0 in the top bits.
    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
        logic [31:0] w [60];
        logic [7:0]  s [16];
        logic [7:0]  t [16];
        logic [7:0]  rc [11];
        logic [31:0] tmp;
        logic [7:0]  a0, a1, a2, a3, all;
        logic [127:0] res;
        int nk, nr;
        rc = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
        nk = (sh_mode == 2'd0) ? 4 : (sh_mode == 2'd1) ? 6 : 8;
        nr = nk + 6;
        for (int i = 0; i < nk; i++)
            w[i] = (i % 2 == 0) ? sh_key[i / 2][63:32] : sh_key[i / 2][31:0];
        for (int i = nk; i < 4 * (nr + 1); i++)
        begin
            tmp = w[i - 1];
            if (i % nk == 0)
            begin
                tmp = {tmp[23:0], tmp[31:24]};
                tmp = {SB[tmp[31:24]], SB[tmp[23:16]], SB[tmp[15:8]], SB[tmp[7:0]]}
                      ^ {rc[i / nk], 24'h0};
            end
            else if (nk > 6 && i % nk == 4)
                tmp = {SB[tmp[31:24]], SB[tmp[23:16]], SB[tmp[15:8]], SB[tmp[7:0]]};
            w[i] = w[i - nk] ^ tmp;
        end
        for (int i = 0; i < 16; i++)
            s[i] = blk[127 - 8 * i -: 8];
        for (int rnd = 0; rnd <= nr; rnd++)
        begin
            if (rnd > 0)
            begin
                for (int i = 0; i < 16; i++)
                    s[i] = SB[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[r + 4 * c] = s[r + 4 * ((c + r) % 4)];
                s = t;
                if (rnd < nr)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ all ^ mul2(a0 ^ a1);
                        s[4*c+1] = a1 ^ all ^ mul2(a1 ^ a2);
                        s[4*c+2] = a2 ^ all ^ mul2(a2 ^ a3);
                        s[4*c+3] = a3 ^ all ^ mul2(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[r + 4 * c] ^= w[4 * rnd + c][31 - 8 * r -: 8];
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    // Advance the shadow stream by one byte and return the ciphered byte.
    function automatic logic [7:0] cipher_byte(input logic [7:0] data, input logic start);
        logic [127:0] ctr_blk;
        logic [7:0] res;
        if (start)
        begin
            sh_counter = '0;
            sh_pos = '0;
        end
        if (sh_pos == 4'd0)
        begin
            ctr_blk[127:64] = sh_nonce;
            for (int i = 0; i < 8; i++)
                ctr_blk[63 - 8 * i -: 8] = sh_counter[8 * i +: 8];
            sh_keystream = aes_encrypt(ctr_blk);
        end
        res = data ^ sh_keystream[127 - 8 * sh_pos -: 8];
        sh_pos = sh_pos + 4'd1;
        if (sh_pos == 4'd0)
            sh_counter = sh_counter + 64'd1;
        return res;
    endfunction

    // Clock, timeout.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: stall in random bursts, check each accepted word.
    initial
    begin
        int burst;
        dout.ready = 1'b0;
        @(posedge clk);
        while (1)
        begin
            if (!drive_done && rx_stall_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 16);
                dout.ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            dout.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && dout.valid && dout.ready)
        begin
            if (cipher_bytes_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected out_byte %02h", dout.out_byte);
            end
            else
            begin
                want = cipher_bytes_q.pop_front();
                if (dout.out_byte !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("out_byte mismatch: expected %02h actual %02h",
                                 want, dout.out_byte);
                end
            end
        end
    end

    // Write one register and update the shadow, then leave the port idle.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            acsc_pkg::CFG_KEY_MODE:  sh_mode = val[1:0];
            acsc_pkg::CFG_KEY_WORD0: sh_key[0] = val;
            acsc_pkg::CFG_KEY_WORD1: sh_key[1] = val;
            acsc_pkg::CFG_KEY_WORD2: sh_key[2] = val;
            acsc_pkg::CFG_KEY_WORD3: sh_key[3] = val;
            acsc_pkg::CFG_NONCE:     sh_nonce = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Send one word; a random idle burst may come first. Expectation is
    // queued once din.ready is seen high after an edge, so order matches the block.
    task automatic send_byte(input logic [7:0] data, input logic start,
                             input logic has_exp, input logic [7:0] exp_byte);
        logic [7:0] predicted;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            din.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        din.valid     <= 1'b1;
        din.data_byte <= data;
        din.start_req <= start;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        predicted = cipher_byte(data, start);
        if (has_exp && predicted !== exp_byte)
            $display("directed row disagrees with prediction");
        cipher_bytes_q.push_back(has_exp ? exp_byte : predicted);
    endtask

    // Wait until every word is back and the block has gone quiet.
    task automatic drain();
        din.valid <= 1'b0;
        @(posedge clk);
        while (cipher_bytes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random stream: mostly messages of a few blocks, some lone start bytes.
    task automatic random_run(input int n_bytes);
        int sent;
        int msg_len;
        sent = 0;
        while (sent < n_bytes)
        begin
            msg_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 60);
            for (int i = 0; i < msg_len && sent < n_bytes; i++)
            begin
                send_byte(8'($urandom_range(0, 255)),
                          i == 0 || $urandom_range(0, 40) == 0,
                          1'b0, 8'h00);
                sent++;
            end
        end
    endtask

    initial
    begin
        dir_row_t rows [$];
        logic [63:0] nonce_val;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = acsc_pkg::CFG_KEY_MODE;
        cfg_data = '0;
        din.valid = 1'b0;
        din.data_byte = '0;
        din.start_req = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        rx_stall_on = 1'b1;
        tx_idle_on = 1'b1;
        drive_done = 1'b0;
        sh_mode = acsc_pkg::MODE_128;
        sh_key = '{default: '0};
        sh_nonce = '0;
        sh_counter = '0;
        sh_keystream = '0;
        sh_pos = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset: all-zero key and block, so byte 0 is the first byte of
        // AES-128(0, 0) = 66 e9 4b d4 ...
        rows.push_back('{8'h00, 1'b1, 1'b1, 8'h66});
        rows.push_back('{8'hff, 1'b0, 1'b1, 8'h16});
        rows.push_back('{8'h00, 1'b0, 1'b1, 8'h4b});
        rows.push_back('{8'h00, 1'b0, 1'b0, 8'h00});
        rows.push_back('{8'ha5, 1'b0, 1'b0, 8'h00});
        // Restart mid-block: same keystream byte 0 again.
        rows.push_back('{8'hff, 1'b1, 1'b1, 8'h99});
        for (int i = 0; i < 15; i++)
            rows.push_back('{8'($urandom), 1'b0, 1'b0, 8'h00});
        rows.push_back('{8'h5a, 1'b0, 1'b0, 8'h00});
        foreach (rows[i])
            send_byte(rows[i].data, rows[i].start, rows[i].has_exp, rows[i].exp_byte);
        drain();

        // Counter wrap: the counter cannot be preset, so check the nonce
        // extremes and a mid-block register write taking effect next block.
        write_reg(acsc_pkg::CFG_KEY_WORD0, 64'hffff_ffff_ffff_ffff);
        write_reg(acsc_pkg::CFG_KEY_WORD1, 64'hffff_ffff_ffff_ffff);
        write_reg(acsc_pkg::CFG_NONCE, 64'hffff_ffff_ffff_ffff);
        for (int i = 0; i < 20; i++)
            send_byte(8'(i * 13), i == 0, 1'b0, 8'h00);
        drain();
        write_reg(acsc_pkg::CFG_NONCE, 64'h0123_4567_89ab_cdef);
        for (int i = 0; i < 12; i++)
            send_byte(8'(i), 1'b0, 1'b0, 8'h00);
        drain();

        // Walk every key mode, the unused code 3 included, plus writes to the two
        // indices past the list, which must change nothing.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(acsc_pkg::CFG_KEY_MODE, (ph == 4) ? 64'd3 : 64'(ph % 3));
            write_reg(acsc_pkg::CFG_KEY_WORD0, rand64());
            write_reg(acsc_pkg::CFG_KEY_WORD1, rand64());
            write_reg(acsc_pkg::CFG_KEY_WORD2, (ph == 2) ? 64'd0 : rand64());
            write_reg(acsc_pkg::CFG_KEY_WORD3,
                      (ph == 2) ? 64'hffff_ffff_ffff_ffff : rand64());
            nonce_val = (ph == 0) ? 64'd0 : rand64();
            write_reg(acsc_pkg::CFG_NONCE, nonce_val);
            write_reg(3'd7, rand64());
            write_reg(3'd6, rand64());
            if (ph == 4)
            begin
                rx_stall_on = 1'b0;
                tx_idle_on = 1'b0;
            end
            random_run(BYTE_COUNT / 5);
            drain();
        end

        drive_done = 1'b1;
        if (mismatch_count == 0 && cipher_bytes_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/acsc_pkg.sv
rtl/acsc_in_if.sv
rtl/acsc_out_if.sv
rtl/acsc_ctrl.sv
rtl/acsc_datapath.sv
rtl/aes_ctr_stream_cipher.sv
test/aes_ctr_stream_cipher_tb.sv
